FILE: sv/u2u_pkg.sv
// shared types, constants and byte encoder of the utf-16 to utf-8 transcoder
`default_nettype none
package u2u_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
   localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPPLEMENT_BASE = 21'h10000;
   localparam logic [20:0] ONE_BYTE_MAX    = 21'h00007F;
   localparam logic [20:0] TWO_BYTE_MAX    = 21'h0007FF;
   localparam logic [20:0] THREE_BYTE_MAX  = 21'h00FFFF;

   // index of the final byte of a code point's encoding
   localparam logic [1:0] LAST_INDEX_ONE   = 2'd0;
   localparam logic [1:0] LAST_INDEX_TWO   = 2'd1;
   localparam logic [1:0] LAST_INDEX_THREE = 2'd2;
   localparam logic [1:0] LAST_INDEX_FOUR  = 2'd3;

   localparam logic CSR_BIG_ENDIAN      = 1'b0;
   localparam logic CSR_SKIP_FIRST_UNIT = 1'b1;

   typedef struct packed {
      logic big_endian;
      logic skip_first_unit;
   } u2u_config_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  last_index;
   } u2u_entry_type;

   typedef struct packed {
      logic          push;
      u2u_entry_type entry;
   } u2u_push_type;

   typedef struct packed {
      logic          empty;
      u2u_entry_type head;
   } u2u_head_type;

   function automatic logic [7:0] encode_byte(input logic [20:0] cp,
                                              input logic [1:0]  last_index,
                                              input logic [1:0]  idx);
      logic [7:0] result;
      logic [1:0] tail;
      result = 8'h00;
      tail = last_index - idx;
      if (idx == 2'd0) begin
         case (last_index)
            LAST_INDEX_ONE:   result = {1'b0, cp[6:0]};
            LAST_INDEX_TWO:   result = {3'b110, cp[10:6]};
            LAST_INDEX_THREE: result = {4'b1110, cp[15:12]};
            LAST_INDEX_FOUR:  result = {5'b11110, cp[20:18]};
            default:          result = 8'h00;
         endcase
      end else begin
         // continuation byte: six bits picked by distance from the end
         case (tail)
            2'd0:    result = {2'b10, cp[5:0]};
            2'd1:    result = {2'b10, cp[11:6]};
            2'd2:    result = {2'b10, cp[17:12]};
            default: result = 8'h80;
         endcase
      end
      return result;
   endfunction

endpackage
`default_nettype wire

FILE: sv/u2u_req_if.sv
// code unit request channel
`default_nettype none
interface u2u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic       first_of_string;

   modport source (output valid, first_byte, second_byte, first_of_string, input ready);
   modport sink   (input valid, first_byte, second_byte, first_of_string, output ready);
endinterface
`default_nettype wire

FILE: sv/u2u_rsp_if.sv
// utf-8 byte response channel
`default_nettype none
interface u2u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

FILE: sv/utf16_to_utf8_transcoder.sv
// top level of the utf-16 to utf-8 transcoder
//
// Takes one UTF-16 code unit per transfer on req_chan and returns its UTF-8
// bytes one per transfer on rsp_chan, last_of_run marking each code point's
// final byte. The front end accepts a unit every cycle while the four-entry
// code point queue has room; units that give no output (zero, lone or
// unpaired surrogates, a skipped first unit, a held high surrogate) are
// still accepted. The back end drains one byte per cycle through its output
// register while rsp_chan is ready; a code point gives 1 to 4 bytes, four
// for a surrogate pair. Each code point is registered in the queue, and each
// of its bytes in the output register before that byte is presented.
// Configuration writes take effect at the next cycle.
`default_nettype none
module utf16_to_utf8_transcoder (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic csr_index,
   input  wire logic csr_write_data,
   u2u_req_if.sink   req_chan,
   u2u_rsp_if.source rsp_chan
);
   import u2u_pkg::*;

   u2u_config_type cfg_ff, cfg_in;
   u2u_push_type   push;
   u2u_head_type   head;
   logic           queue_full;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BIG_ENDIAN:      cfg_in.big_endian = csr_write_data;
            CSR_SKIP_FIRST_UNIT: cfg_in.skip_first_unit = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.big_endian <= 1'b1;
         cfg_ff.skip_first_unit <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   u2u_front front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .req_chan   (req_chan)
   );

   u2u_queue queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   u2u_back back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire

FILE: sv/u2u_front.sv
// front end: byte order, surrogate pairing and code point classification
`default_nettype none
module u2u_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire u2u_pkg::u2u_config_type cfg,
   input  wire logic                    queue_full,
   output u2u_pkg::u2u_push_type        push,
   u2u_req_if.sink                      req_chan
);
   import u2u_pkg::*;

   logic        pending_valid_ff, pending_valid_in;
   logic [9:0]  pending_bits_ff, pending_bits_in;
   logic [15:0] unit;
   logic        accept;
   logic        is_high;
   logic        is_low;
   logic        emit;
   logic [20:0] code_point;
   logic [1:0]  last_index;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   always_comb begin
      unit = cfg.big_endian ? {req_chan.first_byte, req_chan.second_byte}
                            : {req_chan.second_byte, req_chan.first_byte};
      is_high = (unit >= SURR_HIGH_FIRST) && (unit <= SURR_HIGH_LAST);
      is_low  = (unit >= SURR_LOW_FIRST) && (unit <= SURR_LOW_LAST);
      pending_valid_in = pending_valid_ff;
      pending_bits_in = pending_bits_ff;
      emit = 1'b0;
      code_point = {5'd0, unit};
      if (accept) begin
         pending_valid_in = 1'b0;
         if (req_chan.first_of_string && cfg.skip_first_unit) begin
            emit = 1'b0;
         end else if (pending_valid_ff && !req_chan.first_of_string && is_low) begin
            emit = 1'b1;
            code_point = SUPPLEMENT_BASE + {1'b0, pending_bits_ff, unit[9:0]};
         end else if (is_high) begin
            pending_valid_in = 1'b1;
            pending_bits_in = unit[9:0];
         end else begin
            emit = (unit != 16'd0) && !is_low;
         end
      end
      if (code_point <= ONE_BYTE_MAX) begin
         last_index = LAST_INDEX_ONE;
      end else if (code_point <= TWO_BYTE_MAX) begin
         last_index = LAST_INDEX_TWO;
      end else if (code_point <= THREE_BYTE_MAX) begin
         last_index = LAST_INDEX_THREE;
      end else begin
         last_index = LAST_INDEX_FOUR;
      end
      push.push = emit;
      push.entry.code_point = code_point;
      push.entry.last_index = last_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
         pending_bits_ff <= 10'd0;
      end else begin
         pending_valid_ff <= pending_valid_in;
         pending_bits_ff <= pending_bits_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/u2u_queue.sv
// short code point queue between front and back ends
`default_nettype none
module u2u_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u2u_pkg::u2u_push_type push,
   input  wire logic                  pop,
   output logic                       full,
   output u2u_pkg::u2u_head_type      head
);
   import u2u_pkg::*;

   u2u_entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   localparam logic [QUEUE_PTR_WIDTH-1:0] PTR_LAST = QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_COUNT_WIDTH-1:0] COUNT_FULL = QUEUE_COUNT_WIDTH'(QUEUE_DEPTH);

   always_comb begin
      full = (count_ff == COUNT_FULL);
      head.empty = (count_ff == '0);
      head.head = entries_ff[rd_ptr_ff];
      do_push = push.push && !full;
      do_pop = pop && !head.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end
endmodule
`default_nettype wire

FILE: sv/u2u_back.sv
// back end: serializes each queued code point into utf-8 bytes
`default_nettype none
module u2u_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u2u_pkg::u2u_head_type head,
   output logic                       pop,
   u2u_rsp_if.source                  rsp_chan
);
   import u2u_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       take;
   logic       at_last;

   always_comb begin
      // output register refills when empty or its byte is taken this cycle
      load = !rsp_valid_ff || rsp_chan.ready;
      take = load && !head.empty;
      at_last = (idx_ff == head.head.last_index);
      pop = take && at_last;
      idx_in = idx_ff;
      if (take) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
      rsp_valid_in = load ? !head.empty : rsp_valid_ff;
      out_byte_in = out_byte_ff;
      last_in = last_ff;
      if (take) begin
         out_byte_in = encode_byte(head.head.code_point, head.head.last_index, idx_ff);
         last_in = at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.last_of_run = last_ff;
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// testbench of the utf-16 to utf-8 transcoder with its own transcoding predictor
`timescale 1ns / 100ps
module tb;
   import u2u_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int UNITS_PER_SETTING = 82;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } utf8_byte_type;

   typedef enum int {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic csr_index;
   logic csr_write_data;

   u2u_req_if req_chan ();
   u2u_rsp_if rsp_chan ();

   utf16_to_utf8_transcoder DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always #5 clock = ~clock;

   // predictor copy of configuration and surrogate state
   logic       cfg_big_endian = 1'b1;
   logic       cfg_skip_bom   = 1'b0;
   logic [9:0] surr_high_bits = 10'd0;
   logic       surr_held      = 1'b0;

   utf8_byte_type utf8_bytes_due[$];
   int error_count = 0;
   int units_sent = 0;
   int burst_left = 0;
   int cycle_count = 0;

   function automatic void emit_byte(input logic [7:0] value, input logic last);
      utf8_byte_type b;
      b.out_byte = value;
      b.last_of_run = last;
      utf8_bytes_due = {utf8_bytes_due, b};
   endfunction

   function automatic void emit_code_point(input logic [20:0] cp);
      if (cp <= ONE_BYTE_MAX) begin
         emit_byte({1'b0, cp[6:0]}, 1'b1);
      end else if (cp <= TWO_BYTE_MAX) begin
         emit_byte({3'b110, cp[10:6]}, 1'b0);
         emit_byte({2'b10, cp[5:0]}, 1'b1);
      end else if (cp <= THREE_BYTE_MAX) begin
         emit_byte({4'b1110, cp[15:12]}, 1'b0);
         emit_byte({2'b10, cp[11:6]}, 1'b0);
         emit_byte({2'b10, cp[5:0]}, 1'b1);
      end else begin
         emit_byte({5'b11110, cp[20:18]}, 1'b0);
         emit_byte({2'b10, cp[17:12]}, 1'b0);
         emit_byte({2'b10, cp[11:6]}, 1'b0);
         emit_byte({2'b10, cp[5:0]}, 1'b1);
      end
   endfunction

   function automatic void transcode_unit(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic fos);
      logic [15:0] unit;
      if (fos) begin
         surr_held = 1'b0;
         if (cfg_skip_bom) return;
      end
      unit = cfg_big_endian ? {b0, b1} : {b1, b0};
      if (surr_held) begin
         surr_held = 1'b0;
         if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) begin
            emit_code_point(SUPPLEMENT_BASE + 21'({surr_high_bits, unit[9:0]}));
            return;
         end
      end
      if (unit == 16'h0000) return;
      if (unit >= SURR_HIGH_FIRST && unit <= SURR_HIGH_LAST) begin
         surr_high_bits = unit[9:0];
         surr_held = 1'b1;
         return;
      end
      if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) return;
      emit_code_point({5'd0, unit});
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_unit(input logic [7:0] b0, input logic [7:0] b1, input logic fos);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
         gap = $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.first_byte <= b0;
      req_chan.second_byte <= b1;
      req_chan.first_of_string <= fos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      transcode_unit(b0, b1, fos);
      units_sent++;
   endtask

   task automatic send_code_unit(input logic [15:0] unit, input logic fos);
      if (cfg_big_endian) begin
         send_unit(unit[15:8], unit[7:0], fos);
      end else begin
         send_unit(unit[7:0], unit[15:8], fos);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (utf8_bytes_due.size() != 0) @(posedge clock);
      // units with no output may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic value);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == CSR_BIG_ENDIAN) begin
         cfg_big_endian = value;
      end else begin
         cfg_skip_bom = value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_code_point_classes();
      send_code_unit(16'h0041, 1'b1);
      send_code_unit(16'h007F, 1'b0);
      send_code_unit(16'h0080, 1'b0);
      send_code_unit(16'h07FF, 1'b0);
      send_code_unit(16'h0800, 1'b0);
      send_code_unit(16'hFFFF, 1'b0);
      send_code_unit(16'h0000, 1'b0);
   endtask

   task automatic test_surrogates();
      send_code_unit(16'hD800, 1'b0);
      send_code_unit(16'hDC00, 1'b0);
      send_code_unit(16'hDBFF, 1'b0);
      send_code_unit(16'hDFFF, 1'b0);
      // lone low surrogate
      send_code_unit(16'hDC00, 1'b0);
      // held high surrogate dropped by a plain unit
      send_code_unit(16'hD83D, 1'b0);
      send_code_unit(16'h0041, 1'b0);
      // held high surrogate then a zero unit
      send_code_unit(16'hD800, 1'b0);
      send_code_unit(16'h0000, 1'b0);
      // second high surrogate replaces the held one
      send_code_unit(16'hD800, 1'b0);
      send_code_unit(16'hD801, 1'b0);
      send_code_unit(16'hDC05, 1'b0);
      // high surrogate left over at the end of a string
      send_code_unit(16'hD800, 1'b0);
      send_code_unit(16'h0042, 1'b1);
   endtask

   task automatic test_little_endian();
      write_csr(CSR_BIG_ENDIAN, 1'b0);
      send_code_unit(16'h00E9, 1'b1);
      send_code_unit(16'hD83D, 1'b0);
      send_code_unit(16'hDE00, 1'b0);
   endtask

   task automatic test_bom_skip();
      write_csr(CSR_SKIP_FIRST_UNIT, 1'b1);
      send_code_unit(16'hFEFF, 1'b1);
      send_code_unit(16'h0041, 1'b0);
      // skipped first unit still clears the held surrogate
      send_code_unit(16'hD800, 1'b0);
      send_code_unit(16'hDC00, 1'b1);
      send_code_unit(16'hDC00, 1'b0);
   endtask

   task automatic send_random_string();
      int len;
      int kind;
      logic [15:0] hi;
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 1) == 0) begin
         send_code_unit(16'hFEFF, 1'b1);
      end else begin
         send_unit(8'($urandom), 8'($urandom), 1'b1);
      end
      repeat (len) begin
         kind = $urandom_range(0, 15);
         if (kind <= 3) begin
            send_code_unit(16'($urandom_range(1, 16'h007F)), 1'b0);
         end else if (kind <= 5) begin
            send_code_unit(16'($urandom_range(16'h0080, 16'h07FF)), 1'b0);
         end else if (kind <= 7) begin
            if ($urandom_range(0, 1) == 0) begin
               send_code_unit(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0);
            end else begin
               send_code_unit(16'($urandom_range(16'hE000, 16'hFFFF)), 1'b0);
            end
         end else if (kind <= 10) begin
            hi = 16'($urandom_range(SURR_HIGH_FIRST, SURR_HIGH_LAST));
            send_code_unit(hi, 1'b0);
            send_code_unit(16'($urandom_range(SURR_LOW_FIRST, SURR_LOW_LAST)), 1'b0);
         end else if (kind == 11) begin
            send_code_unit(16'h0000, 1'b0);
         end else if (kind == 12) begin
            send_code_unit(16'($urandom_range(SURR_LOW_FIRST, SURR_LOW_LAST)), 1'b0);
         end else if (kind == 13) begin
            send_code_unit(16'($urandom_range(SURR_HIGH_FIRST, SURR_HIGH_LAST)), 1'b0);
         end else if (kind == 14) begin
            send_unit(8'($urandom), 8'($urandom), 1'b0);
         end else begin
            send_unit(8'($urandom), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic test_random_strings();
      int setting;
      int target;
      for (setting = 0; setting < 4; setting++) begin
         write_csr(CSR_BIG_ENDIAN, setting[0]);
         write_csr(CSR_SKIP_FIRST_UNIT, setting[1]);
         target = units_sent + UNITS_PER_SETTING;
         while (units_sent < target) send_random_string();
      end
   endtask

   // receiver: ready follows a mode that is chosen anew after each random span
   rx_mode_type rx_mode = RX_FREE;
   logic [15:0] stall_pattern = 16'hFFFF;
   int rx_span = 0;

   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         stall_pattern = 16'($urandom) | 16'h0001;
         rx_span = $urandom_range(20, 120);
      end else begin
         rx_span--;
      end
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      case (rx_mode)
         RX_FREE:    rsp_chan.ready <= 1'b1;
         RX_PATTERN: rsp_chan.ready <= stall_pattern[0];
         default:    rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      utf8_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (utf8_bytes_due.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual out_byte %h last_of_run %b",
                     $time, rsp_chan.out_byte, rsp_chan.last_of_run);
            error_count++;
         end else begin
            want = utf8_bytes_due.pop_front();
            if (rsp_chan.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, want.out_byte, rsp_chan.out_byte);
               error_count++;
            end
            if (rsp_chan.last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run mismatch: expected %b, actual %b",
                        $time, want.last_of_run, rsp_chan.last_of_run);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.first_byte = 8'h00;
      req_chan.second_byte = 8'h00;
      req_chan.first_of_string = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_BIG_ENDIAN;
      csr_write_data = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_code_point_classes();
      test_surrogates();
      test_little_endian();
      test_bom_skip();
      test_random_strings();

      wait_drained();
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: utf16_to_utf8_transcoder.f
sv/u2u_pkg.sv
sv/u2u_req_if.sv
sv/u2u_rsp_if.sv
sv/u2u_front.sv
sv/u2u_queue.sv
sv/u2u_back.sv
sv/utf16_to_utf8_transcoder.sv
tb/sv/tb.sv
